/* rtl/core/value_list_table_engine_assert.svh */
// assertion macros for the value list table engine, sampled on clk, off in reset
`ifndef VALUE_LIST_TABLE_ENGINE_ASSERT_SVH
`define VALUE_LIST_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication
`define VLTE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vlte: same-cycle check failed");

// next-cycle implication
`define VLTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vlte: next-cycle check failed");

`endif

/* rtl/core/vlte_pkg.sv */
// shared types and constants of the value list table engine
package vlte_pkg;

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_MARK    = 2'd1,
        MODE_COMPACT = 2'd2,
        MODE_SEARCH  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ZERO      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } sts_t;

    localparam logic [31:0]       TOMBSTONE = 32'hFFFF_FFFF;
    localparam logic signed [7:0] POS_NONE  = 8'shFF;

endpackage

/* rtl/core/vlte_req_if.sv */
// request channel: mode and value word with valid/ready
interface vlte_req_if;
    logic               valid;
    logic               ready;
    vlte_pkg::mode_t    mode;
    logic signed [31:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

/* rtl/core/vlte_rsp_if.sv */
// response channel: status, position and occupancy word with valid/ready
interface vlte_rsp_if;
    logic              valid;
    logic              ready;
    vlte_pkg::status_t status;
    logic signed [7:0] position;
    logic [7:0]        occupancy;

    modport source (output valid, output status, output position, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input position, input occupancy,
                    output ready);
endinterface

/* rtl/core/vlte_datapath.sv */
// entry memory, scan counters, compare and result registers
module vlte_datapath #(
    parameter int unsigned CAPACITY = 128,
    localparam int unsigned IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vlte_pkg::cmd_t     cmd,
    output vlte_pkg::sts_t     sts,
    input  vlte_pkg::mode_t    req_mode,
    input  logic signed [31:0] req_value,
    output vlte_pkg::status_t  rsp_status,
    output logic signed [7:0]  rsp_position,
    output logic [7:0]         rsp_occupancy
);
    import vlte_pkg::*;

    logic [31:0]       mem [CAPACITY];

    mode_t             mode_reg;
    logic [31:0]       value_reg;
    status_t           app_status_reg, app_status_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic              pipe_vld_reg;
    logic [IDX_W-1:0]  pipe_idx_reg;
    logic [31:0]       rd_data_reg;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    status_t           status_reg, status_next;
    logic signed [7:0] position_reg, position_next;
    logic [7:0]        occupancy_reg, occupancy_next;

    logic              rd_en;
    logic              match;
    logic              full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [31:0]       wr_data;
    logic [CNT_W-1:0]  occ_val;
    logic [IDX_W+7:0]  first_ext;
    logic [CNT_W+7:0]  occ_ext;

    // read one stored entry per scan cycle
    assign rd_en = cmd.scan && (idx_reg < count_reg);
    assign match = pipe_vld_reg && (rd_data_reg == value_reg);
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign sts.scan_done = cmd.scan && !rd_en && !pipe_vld_reg;

    // single write port: append, tombstone or compaction move
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = req_value;
        if (cmd.start)
        begin
            wr_en = (req_mode == MODE_APPEND) && (req_value != 32'sd0) && !full;
        end
        else if (pipe_vld_reg)
        begin
            if (mode_reg == MODE_MARK && match)
            begin
                wr_en   = 1'b1;
                wr_addr = pipe_idx_reg;
                wr_data = TOMBSTONE;
            end
            else if (mode_reg == MODE_COMPACT && !match)
            begin
                wr_en   = 1'b1;
                wr_addr = w_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
            end
        end
    end

    // scan bookkeeping and count update
    always_comb
    begin
        idx_next        = idx_reg;
        w_next          = w_reg;
        hit_next        = hit_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        app_status_next = app_status_reg;
        occ_val         = (mode_reg == MODE_COMPACT) ? w_reg : count_reg;
        if (cmd.start)
        begin
            idx_next = '0;
            w_next   = '0;
            hit_next = 1'b0;
            if (req_value == 32'sd0)
            begin
                app_status_next = ST_ZERO;
            end
            else if (full)
            begin
                app_status_next = ST_FULL;
            end
            else
            begin
                app_status_next = ST_OK;
            end
            if (req_mode == MODE_APPEND && req_value != 32'sd0 && !full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (rd_en)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (pipe_vld_reg && match)
            begin
                hit_next = 1'b1;
                if (!hit_reg)
                begin
                    first_next = pipe_idx_reg;
                end
            end
            if (pipe_vld_reg && mode_reg == MODE_COMPACT && !match)
            begin
                w_next = w_reg + CNT_W'(1);
            end
            if (cmd.load)
            begin
                count_next = occ_val;
            end
        end
    end

    // result word, low 8 bits of index and count
    assign first_ext = {8'b0, first_reg};
    assign occ_ext   = {8'b0, occ_val};

    always_comb
    begin
        status_next    = status_reg;
        position_next  = position_reg;
        occupancy_next = occupancy_reg;
        if (cmd.load)
        begin
            occupancy_next = occ_ext[7:0];
            if (mode_reg == MODE_APPEND)
            begin
                status_next = app_status_reg;
            end
            else
            begin
                status_next = hit_reg ? ST_OK : ST_NOT_FOUND;
            end
            if (mode_reg == MODE_SEARCH && hit_reg)
            begin
                position_next = first_ext[7:0];
            end
            else
            begin
                position_next = POS_NONE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            w_reg        <= '0;
            hit_reg      <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            w_reg        <= w_next;
            hit_reg      <= hit_next;
            pipe_vld_reg <= rd_en;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg  <= req_mode;
            value_reg <= req_value;
        end
        if (rd_en)
        begin
            pipe_idx_reg <= idx_reg[IDX_W-1:0];
        end
        app_status_reg <= app_status_next;
        first_reg      <= first_next;
        status_reg     <= status_next;
        position_reg   <= position_next;
        occupancy_reg  <= occupancy_next;
    end

    // entry memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign rsp_status    = status_reg;
    assign rsp_position  = position_reg;
    assign rsp_occupancy = occupancy_reg;

endmodule

/* rtl/core/vlte_ctrl.sv */
// controller: request intake, scan sequencing and response handoff
module vlte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_is_append,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output vlte_pkg::cmd_t cmd,
    input  vlte_pkg::sts_t sts
);
    import vlte_pkg::*;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = req_is_append ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hand the word over once the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/core/value_list_table_engine.sv */
// top level of the value list table engine
//
//   channel   dir   word contents                       handshake
//   req       in    mode, value                         valid/ready
//   rsp       out   status, position, occupancy         valid/ready
//
// append goes from accept straight to the result; remove and search first scan the
// stored entries through the single read port of the entry memory, one entry per cycle.
// reset clears the count and control state; entry contents stay unknown.
// a new word is taken while an earlier result still waits in the output register;
// the next result waits until that register is free.
`include "value_list_table_engine_assert.svh"

module value_list_table_engine #(
    parameter int unsigned CAPACITY = 128
) (
    input logic         clk,
    input logic         rst_n,
    vlte_req_if.sink    req,
    vlte_rsp_if.source  rsp
);
    import vlte_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    vlte_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_is_append (req.mode == MODE_APPEND),
        .req_ready     (req.ready),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .cmd           (cmd),
        .sts           (sts)
    );

    // storage and compare
    vlte_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_mode      (req.mode),
        .req_value     (req.value),
        .rsp_status    (rsp.status),
        .rsp_position  (rsp.position),
        .rsp_occupancy (rsp.occupancy)
    );

    // checks
    `VLTE_ASSERT_IMP(a_start_on_accept, cmd.start, req.valid && req.ready)
    `VLTE_ASSERT_IMP(a_no_overwrite, cmd.load, !(rsp.valid && !rsp.ready))
    `VLTE_ASSERT_NEXT(a_load_shows_valid, cmd.load, rsp.valid)
    `VLTE_ASSERT_IMP(a_single_cmd, 1'b1, $onehot0({cmd.start, cmd.scan, cmd.load}))

endmodule

/* tb/sv/value_list_table_engine_test.sv */
// self-checking testbench for the value list table engine: append, remove and search words
module value_list_table_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vlte_pkg::*;

    localparam int LIST_DEPTH   = 128;
    localparam int RANDOM_WORDS = 650;
    localparam int PHASE_WORDS  = 160;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 20;
    localparam int PRINT_LIMIT  = 40;

    // weight bands for random word shaping
    typedef enum int {
        PH_FILL,
        PH_MIX,
        PH_DRAIN,
        PH_MIX_LATE
    } phase_t;

    typedef struct packed {
        status_t           status;
        logic signed [7:0] position;
        logic [7:0]        occupancy;
    } list_result_t;

    // shadow list and queue of results owed by the block
    class list_scoreboard;
        logic [31:0]  entries [LIST_DEPTH];
        int unsigned  count;
        list_result_t pending [$];
        int           errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        task report(string what);
            if (errors < PRINT_LIMIT)
                $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        // apply one request word to the shadow list and queue its result
        function void note_request(mode_t mode, logic [31:0] value);
            list_result_t r;
            int unsigned  w;
            bit           hit;
            r.status   = ST_OK;
            r.position = POS_NONE;
            hit        = 1'b0;
            w          = 0;
            case (mode)
                MODE_APPEND:
                begin
                    if (value == 32'd0)
                        r.status = ST_ZERO;
                    else if (count >= LIST_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        entries[count] = value;
                        count++;
                    end
                end
                MODE_MARK:
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        if (entries[i] == value)
                        begin
                            entries[i] = TOMBSTONE;
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        r.status = ST_NOT_FOUND;
                end
                MODE_COMPACT:
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        if (entries[i] == value)
                            hit = 1'b1;
                        else
                        begin
                            entries[w] = entries[i];
                            w++;
                        end
                    end
                    count = w;
                    if (!hit)
                        r.status = ST_NOT_FOUND;
                end
                default:
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        if (!hit && entries[i] == value)
                        begin
                            r.position = 8'(i);
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        r.status = ST_NOT_FOUND;
                end
            endcase
            r.occupancy = 8'(count);
            pending.push_back(r);
        endfunction

        // compare one accepted result word with the oldest owed result
        task check_response(status_t status, logic signed [7:0] position,
                            logic [7:0] occupancy);
            list_result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result word with nothing owed (status %0d)", status));
                return;
            end
            want = pending.pop_front();
            if (status !== want.status)
                report($sformatf("status got %0d want %0d", status, want.status));
            if (position !== want.position)
                report($sformatf("position got %0d want %0d", position, want.position));
            if (occupancy !== want.occupancy)
                report($sformatf("occupancy got %0d want %0d", occupancy, want.occupancy));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vlte_req_if req ();
    vlte_rsp_if rsp ();

    list_scoreboard sb = new();

    int burst_left    = 0;
    bit sender_steady = 1'b0;
    int idle_cycles   = 0;

    value_list_table_engine #(
        .CAPACITY (LIST_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // monitor both channels and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                sb.note_request(req.mode, req.value);
            if (rsp.valid && rsp.ready)
                sb.check_response(rsp.status, rsp.position, rsp.occupancy);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver stall pattern: short toggles, rare long stalls, some steady stretches
    initial
    begin
        int hold_high;
        int hold_low;
        rsp.ready = 1'b0;
        forever
        begin
            hold_high = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
            @(negedge clk);
            rsp.ready <= 1'b1;
            repeat (hold_high - 1) @(negedge clk);
            hold_low = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
            @(negedge clk);
            rsp.ready <= 1'b0;
            repeat (hold_low - 1) @(negedge clk);
        end
    end

    // drive one request word in bursts; entered and left at a falling edge
    task send_word(input mode_t mode, input logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_steady ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req.mode  <= mode;
        req.value <= value;
        req.valid <= 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // value mix: small repeating pool so removes and searches hit, plus full-width noise
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 32'd0;
        else if (r < 13)
            return TOMBSTONE;
        else if (r < 48)
            return 32'($urandom_range(1, 6));
        else if (r < 56)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0001;
                default: return 32'hFFFF_FFFE;
            endcase
        end
        return $urandom;
    endfunction

    function automatic mode_t pick_mode(phase_t phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:
                return (r < 95) ? MODE_APPEND : MODE_SEARCH;
            PH_DRAIN:
            begin
                if (r < 50) return MODE_COMPACT;
                if (r < 70) return MODE_MARK;
                if (r < 85) return MODE_SEARCH;
                return MODE_APPEND;
            end
            default:
            begin
                if (r < 40) return MODE_APPEND;
                if (r < 60) return MODE_MARK;
                if (r < 75) return MODE_COMPACT;
                return MODE_SEARCH;
            end
        endcase
    endfunction

    initial
    begin
        phase_t phase;
        req.valid = 1'b0;
        req.mode  = MODE_APPEND;
        req.value = 32'd0;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list, zero refusal, extremes, tombstones, no-match removes
        send_word(MODE_SEARCH,  32'd5);
        send_word(MODE_MARK,    32'd5);
        send_word(MODE_COMPACT, 32'd5);
        send_word(MODE_APPEND,  32'd0);
        send_word(MODE_APPEND,  32'h7FFF_FFFF);
        send_word(MODE_APPEND,  32'h8000_0000);
        send_word(MODE_APPEND,  TOMBSTONE);
        send_word(MODE_APPEND,  32'd5);
        send_word(MODE_APPEND,  32'd5);
        send_word(MODE_APPEND,  32'd7);
        send_word(MODE_SEARCH,  32'd5);
        send_word(MODE_SEARCH,  32'h8000_0000);
        send_word(MODE_MARK,    32'd5);
        send_word(MODE_SEARCH,  32'd5);
        send_word(MODE_SEARCH,  TOMBSTONE);
        send_word(MODE_MARK,    32'd9);
        send_word(MODE_COMPACT, 32'd9);
        send_word(MODE_COMPACT, TOMBSTONE);
        send_word(MODE_SEARCH,  32'd7);
        send_word(MODE_MARK,    32'h7FFF_FFFF);
        send_word(MODE_COMPACT, 32'h8000_0000);
        send_word(MODE_SEARCH,  32'd0);
        send_word(MODE_MARK,    32'd0);

        // random: fill, mix, drain, mix again, then a short fill
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            phase = phase_t'((k / PHASE_WORDS) % 4);
            sender_steady = (k >= 200 && k < 280);
            send_word(pick_mode(phase), pick_value());
        end
        req.valid <= 1'b0;

        // wait for every owed result, then let the block settle
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
